// ===== design/max_weight_key_window_defines.svh =====
`ifndef MAX_WEIGHT_KEY_WINDOW_DEFINES_SVH
`define MAX_WEIGHT_KEY_WINDOW_DEFINES_SVH

// checks that hold outside reset
`define MWKW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m check failed");

// checks that hold during reset as well
`define MWKW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m check failed");

`endif

// ===== design/mwkw_pkg.sv =====
package mwkw_pkg;

  localparam int KEY_W = 32;
  localparam int WGT_W = 32;
  localparam int SUM_W = 42;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_OUT_RD,
    ST_OUT_LAT,
    ST_SCAN,
    ST_DRAIN,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_acc;
    logic start;
    logic outer_rd;
    logic outer_lat;
    logic scan;
    logic cmp;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic i_last;
    logic j_last;
  } status_t;

endpackage

// ===== design/mwkw_ram.sv =====
module mwkw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mwkw_ctrl.sv =====
module mwkw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_item,
  input  logic              out_stall,
  input  mwkw_pkg::status_t status,
  output mwkw_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);

  mwkw_pkg::state_t state;
  mwkw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwkw_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mwkw_pkg::ST_LOAD: begin
        if (in_valid && last_item) state_next = mwkw_pkg::ST_START;
      end
      mwkw_pkg::ST_START: begin
        state_next = status.count_zero ? mwkw_pkg::ST_DONE : mwkw_pkg::ST_OUT_RD;
      end
      mwkw_pkg::ST_OUT_RD:  state_next = mwkw_pkg::ST_OUT_LAT;
      mwkw_pkg::ST_OUT_LAT: state_next = mwkw_pkg::ST_SCAN;
      mwkw_pkg::ST_SCAN: begin
        if (status.j_last) state_next = mwkw_pkg::ST_DRAIN;
      end
      mwkw_pkg::ST_DRAIN: state_next = mwkw_pkg::ST_CMP;
      mwkw_pkg::ST_CMP: begin
        state_next = status.i_last ? mwkw_pkg::ST_DONE : mwkw_pkg::ST_OUT_RD;
      end
      mwkw_pkg::ST_DONE: begin
        if (!out_stall) state_next = mwkw_pkg::ST_LOAD;
      end
      default: state_next = mwkw_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      mwkw_pkg::ST_LOAD: begin
        in_stall     = 1'b0;
        cmd.load_acc = in_valid;
      end
      mwkw_pkg::ST_START:   cmd.start     = 1'b1;
      mwkw_pkg::ST_OUT_RD:  cmd.outer_rd  = 1'b1;
      mwkw_pkg::ST_OUT_LAT: cmd.outer_lat = 1'b1;
      mwkw_pkg::ST_SCAN:    cmd.scan      = 1'b1;
      mwkw_pkg::ST_DRAIN:   cmd           = '0;
      mwkw_pkg::ST_CMP:     cmd.cmp       = 1'b1;
      mwkw_pkg::ST_DONE: begin
        out_valid = 1'b1;
        cmd.clear = !out_stall;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/mwkw_datapath.sv =====
module mwkw_datapath #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mwkw_pkg::cmd_t               cmd,
  input  logic [mwkw_pkg::KEY_W-1:0]   item_key,
  input  logic [mwkw_pkg::WGT_W-1:0]   item_weight,
  input  logic [mwkw_pkg::KEY_W-1:0]   window_width,
  output mwkw_pkg::status_t            status,
  output logic [mwkw_pkg::SUM_W-1:0]   best_sum,
  output logic                         overflow
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int TOT_W = mwkw_pkg::WGT_W + CNT_W;
  localparam int EXT_W = (TOT_W > mwkw_pkg::SUM_W) ? TOT_W : mwkw_pkg::SUM_W;
  localparam int MEM_W = mwkw_pkg::KEY_W + mwkw_pkg::WGT_W;

  logic [CNT_W-1:0]           count;
  logic                       ovf;
  logic [IDX_W-1:0]           i_idx;
  logic [IDX_W-1:0]           j_idx;
  logic [mwkw_pkg::KEY_W-1:0] low;
  logic [mwkw_pkg::KEY_W:0]   high;
  logic [TOT_W-1:0]           total;
  logic [TOT_W-1:0]           best;
  logic                       rd_v;
  logic [IDX_W-1:0]           raddr;
  logic [MEM_W-1:0]           rdata;
  logic [mwkw_pkg::KEY_W-1:0] rd_key;
  logic [mwkw_pkg::WGT_W-1:0] rd_wgt;
  logic                       full;
  logic                       we;
  logic                       in_win;
  logic [EXT_W-1:0]           best_ext;
  logic [CNT_W-1:0]           count_m1;

  assign full     = (count == CNT_W'(MAX_ITEMS));
  assign we       = cmd.load_acc && !full;
  assign raddr    = cmd.scan ? j_idx : i_idx;
  assign rd_key   = rdata[MEM_W-1 -: mwkw_pkg::KEY_W];
  assign rd_wgt   = rdata[mwkw_pkg::WGT_W-1:0];
  assign in_win   = (rd_key >= low) && ({1'b0, rd_key} < high);
  assign count_m1 = count - CNT_W'(1);

  mwkw_ram #(.WIDTH(MEM_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({item_key, item_weight}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= cmd.scan;
      if (cmd.clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (cmd.load_acc) begin
        if (full) ovf <= 1'b1;
        else      count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best  <= '0;
      i_idx <= '0;
    end
    if (cmd.outer_lat) begin
      low   <= rd_key;
      high  <= {1'b0, rd_key} + {1'b0, window_width};
      total <= '0;
      j_idx <= '0;
    end
    if (cmd.scan) j_idx <= j_idx + IDX_W'(1);
    if (rd_v && in_win) total <= total + TOT_W'(rd_wgt);
    if (cmd.cmp) begin
      if (total > best) best <= total;
      i_idx <= i_idx + IDX_W'(1);
    end
  end

  assign status.count_zero = (count == '0);
  assign status.i_last     = (CNT_W'(i_idx) == count_m1);
  assign status.j_last     = (CNT_W'(j_idx) == count_m1);

  assign best_ext = EXT_W'(best);
  assign best_sum = (best_ext > EXT_W'(mwkw_pkg::SUM_MAX)) ? mwkw_pkg::SUM_MAX
                                                           : best_ext[mwkw_pkg::SUM_W-1:0];
  assign overflow = ovf;

endmodule

// ===== design/max_weight_key_window.sv =====
// Loads (key, weight) beats one per cycle into a single-port-read store until a beat with
// last_item set, then tries every stored key as the low end of the window and scans the
// whole store for each, one stored item at a time through the one store read port, before
// the result beat is offered.
// Items past MAX_ITEMS are dropped and reported through overflow. No input is taken while a
// set is being worked or its result waits.
`include "max_weight_key_window_defines.svh"

module max_weight_key_window #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] item_key,
  input  logic [31:0] item_weight,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [41:0] best_sum,
  output logic        overflow
);

  mwkw_pkg::cmd_t    cmd;
  mwkw_pkg::status_t status;
  logic [mwkw_pkg::KEY_W-1:0] window_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= mwkw_pkg::KEY_W'(1);
    end else if (cfg_write_en) begin
      window_width <= cfg_write_data;
    end
  end

  mwkw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_item (last_item),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  mwkw_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item_key     (item_key),
    .item_weight  (item_weight),
    .window_width (window_width),
    .status       (status),
    .best_sum     (best_sum),
    .overflow     (overflow)
  );

  `MWKW_ASSERT(a_no_load_with_result, !in_stall |-> !out_valid)
  `MWKW_ASSERT(a_last_closes_set, in_valid && !in_stall && last_item |=> in_stall)
  `MWKW_ASSERT(a_result_reopens, out_valid && !out_stall |=> !in_stall && !out_valid)

endmodule
